>>> hw/rtl/biq_pkg.sv
// Shared types and constants for the biquad IIR filter unit.
// Holds the register index codes, sequencer states and control bundle.
// No dependencies.
package biq_pkg;

  // Configuration register file.
  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;

  // Integer bits of every Q-format value, and extra fraction bits of the output history.
  localparam int INT_BITS   = 4;
  localparam int HIST_EXTRA = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_NEWEST_IN  = 3'd0,
    REG_GAIN_PREV_IN    = 3'd1,
    REG_GAIN_OLDEST_IN  = 3'd2,
    REG_GAIN_PREV_OUT   = 3'd3,
    REG_GAIN_OLDEST_OUT = 3'd4,
    REG_RECIP_LEAD_OUT  = 3'd5
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_SCALE,
    ST_DONE
  } state_t;

  // Product taps in the order the shared multiplier takes them.
  typedef enum logic [2:0] {
    TAP_NEWEST_IN,
    TAP_PREV_IN,
    TAP_OLDEST_IN,
    TAP_PREV_OUT,
    TAP_OLDEST_OUT
  } tap_t;

  // Datapath controls decoded from the sequencer state.
  typedef struct packed {
    logic in_ready;
    logic issue_mul;
    logic acc_add;
    logic load_diff;
    logic scale_mul;
    logic finish;
  } ctrl_t;

endpackage

>>> hw/rtl/biquad_iir_filter_unit.sv
// Direct form I biquad filter with one shared multiplier under a small sequencer.
// Depends on biq_pkg.
//
// The result is presented after the MAC, DRAIN, ROUND, SCALE and DONE states that follow the
// input transfer, later only while an earlier result still waits on the output. No new
// sample is taken before then, since the single multiplier forms six products in turn.
// Reset (rst, synchronous, active high) clears the sample and output history,
// loads the coefficient defaults (unity forward gain and reciprocal) and empties the output.
module biquad_iir_filter_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 24,
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [TDATA_W-1:0]            s_axis_tdata,  // [SAMPLE_BITS-1:0] sample_in
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [TDATA_W-1:0]            m_axis_tdata,  // [SAMPLE_BITS-1:0] sample_out
  output logic [0:0]                    m_axis_tuser,  // [0] clipped
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [biq_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data
);
  import biq_pkg::*;

  localparam int COEF_FRAC = COEF_BITS - INT_BITS;
  localparam int HIST_BITS = SAMPLE_BITS + HIST_EXTRA;
  // Rounded difference: five products of up to COEF_BITS + HIST_BITS bits, minus the shift.
  localparam int DIFF_BITS = COEF_BITS + HIST_BITS + 3 - COEF_FRAC;
  localparam int PROD_BITS = COEF_BITS + DIFF_BITS;
  localparam int Y_BITS    = PROD_BITS - COEF_FRAC;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    {{(COEF_BITS-1){1'b0}}, 1'b1} << COEF_FRAC;
  localparam logic signed [PROD_BITS-1:0] PROD_HALF =
    {{(PROD_BITS-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);
  localparam logic signed [HIST_BITS:0] HIST_HALF =
    {{HIST_BITS{1'b0}}, 1'b1} << (HIST_EXTRA - 1);
  localparam logic signed [HIST_BITS-1:0] HIST_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
  localparam logic signed [HIST_BITS-1:0] HIST_MIN = {1'b1, {(HIST_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  state_t state, state_next;
  ctrl_t  ctrl;
  tap_t   tap, prod_tap;

  // Coefficients.
  logic signed [COEF_BITS-1:0] gain_newest_in, gain_prev_in, gain_oldest_in;
  logic signed [COEF_BITS-1:0] gain_prev_out, gain_oldest_out, recip_lead_out;

  // History and working registers.
  logic signed [SAMPLE_BITS-1:0] x_cur, x_prev, x_oldest;
  logic signed [HIST_BITS-1:0]   y_prev, y_oldest;
  logic signed [PROD_BITS-1:0]   prod, acc;
  logic signed [DIFF_BITS-1:0]   diff;
  logic [SAMPLE_BITS-1:0]        out_sample;
  logic                          out_clipped;
  logic                          out_valid;

  // Combinational datapath.
  logic signed [COEF_BITS-1:0]   mul_a;
  logic signed [DIFF_BITS-1:0]   mul_b;
  logic signed [PROD_BITS-1:0]   mul_p, acc_term, acc_round, y_round;
  logic signed [Y_BITS-1:0]      y_full;
  logic [Y_BITS-HIST_BITS:0]     y_top;
  logic                          y_fits;
  logic signed [HIST_BITS-1:0]   y_sat;
  logic signed [HIST_BITS:0]     s_round;
  logic [SAMPLE_BITS:0]          s_full;
  logic                          s_fits;
  logic [SAMPLE_BITS-1:0]        s_sat;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_MAC;
      ST_MAC:   if (tap == TAP_OLDEST_OUT) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_ROUND;
      ST_ROUND: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DONE;
      ST_DONE:  if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath controls decoded from the state.
  always_comb begin
    ctrl           = '0;
    ctrl.in_ready  = (state == ST_IDLE);
    ctrl.issue_mul = (state == ST_MAC);
    ctrl.acc_add   = ((state == ST_MAC) && (tap != TAP_NEWEST_IN)) || (state == ST_DRAIN);
    ctrl.load_diff = (state == ST_ROUND);
    ctrl.scale_mul = (state == ST_SCALE);
    ctrl.finish    = (state == ST_DONE) && (!out_valid || m_axis_tready);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = recip_lead_out;
    mul_b = diff;
    if (!ctrl.scale_mul) begin
      case (tap)
        TAP_NEWEST_IN: begin
          mul_a = gain_newest_in;
          mul_b = DIFF_BITS'(x_cur);
        end
        TAP_PREV_IN: begin
          mul_a = gain_prev_in;
          mul_b = DIFF_BITS'(x_prev);
        end
        TAP_OLDEST_IN: begin
          mul_a = gain_oldest_in;
          mul_b = DIFF_BITS'(x_oldest);
        end
        TAP_PREV_OUT: begin
          mul_a = gain_prev_out;
          mul_b = DIFF_BITS'(y_prev);
        end
        TAP_OLDEST_OUT: begin
          mul_a = gain_oldest_out;
          mul_b = DIFF_BITS'(y_oldest);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // Forward products gain the extra history fraction bits; feedback products subtract.
  always_comb begin
    case (prod_tap)
      TAP_PREV_OUT, TAP_OLDEST_OUT: acc_term = -prod;
      default:                      acc_term = prod <<< HIST_EXTRA;
    endcase
  end

  // Round half up of the accumulated difference to the coefficient fraction.
  assign acc_round = acc + PROD_HALF;

  // Round the scaled result, then clamp it to the history width.
  assign y_round = prod + PROD_HALF;
  assign y_full  = y_round[PROD_BITS-1:COEF_FRAC];
  assign y_top   = y_full[Y_BITS-1:HIST_BITS-1];
  assign y_fits  = (&y_top) || !(|y_top);
  always_comb begin
    if (y_fits) y_sat = y_full[HIST_BITS-1:0];
    else if (y_full[Y_BITS-1]) y_sat = HIST_MIN;
    else y_sat = HIST_MAX;
  end

  // Round the clamped value to the sample format; only the top can overflow.
  assign s_round = {y_sat[HIST_BITS-1], y_sat} + HIST_HALF;
  assign s_full  = s_round[HIST_BITS:HIST_EXTRA];
  assign s_fits  = (s_full[SAMPLE_BITS] == s_full[SAMPLE_BITS-1]);
  always_comb begin
    if (s_fits) s_sat = s_full[SAMPLE_BITS-1:0];
    else if (s_full[SAMPLE_BITS]) s_sat = SAMPLE_MIN;
    else s_sat = SAMPLE_MAX;
  end

  // Control, coefficient and history registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      tap             <= TAP_NEWEST_IN;
      out_valid       <= 1'b0;
      gain_newest_in  <= COEF_ONE;
      gain_prev_in    <= '0;
      gain_oldest_in  <= '0;
      gain_prev_out   <= '0;
      gain_oldest_out <= '0;
      recip_lead_out  <= COEF_ONE;
      x_prev          <= '0;
      x_oldest        <= '0;
      y_prev          <= '0;
      y_oldest        <= '0;
    end else begin
      state <= state_next;

      // Register writes; indexes past the list are dropped.
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN_NEWEST_IN:  gain_newest_in  <= cfg_data;
          REG_GAIN_PREV_IN:    gain_prev_in    <= cfg_data;
          REG_GAIN_OLDEST_IN:  gain_oldest_in  <= cfg_data;
          REG_GAIN_PREV_OUT:   gain_prev_out   <= cfg_data;
          REG_GAIN_OLDEST_OUT: gain_oldest_out <= cfg_data;
          REG_RECIP_LEAD_OUT:  recip_lead_out  <= cfg_data;
          default: ;
        endcase
      end

      // Tap counter walks the five products of one item.
      if (ctrl.in_ready && s_axis_tvalid) begin
        tap <= TAP_NEWEST_IN;
      end else if (ctrl.issue_mul && (tap != TAP_OLDEST_OUT)) begin
        tap <= tap_t'(tap + 3'd1);
      end

      // Shift the history once the new output is settled.
      if (ctrl.finish) begin
        x_prev   <= x_cur;
        x_oldest <= x_prev;
        y_prev   <= y_sat;
        y_oldest <= y_prev;
      end

      // Output register holds its result until the transfer.
      if (ctrl.finish) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // Working registers of the shared multiplier and accumulator.
  always_ff @(posedge clk) begin
    if (ctrl.in_ready && s_axis_tvalid) begin
      x_cur <= s_axis_tdata[SAMPLE_BITS-1:0];
      acc   <= '0;
    end else if (ctrl.acc_add) begin
      acc <= acc + acc_term;
    end
    if (ctrl.issue_mul || ctrl.scale_mul) begin
      prod     <= mul_p;
      prod_tap <= tap;
    end
    if (ctrl.load_diff) diff <= acc_round[COEF_FRAC +: DIFF_BITS];
    if (ctrl.finish) begin
      out_sample  <= s_sat;
      out_clipped <= !y_fits || !s_fits;
    end
  end

  assign s_axis_tready   = ctrl.in_ready;
  assign cfg_ready       = 1'b1;
  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = TDATA_W'(out_sample);
  assign m_axis_tuser[0] = out_clipped;

endmodule

>>> hw/rtl/biq_checker.sv
// Port-level checks for the biquad IIR filter unit, and the bind that attaches them.
// Depends on biquad_iir_filter_unit for the bind target.
module biq_checker #(
  parameter int TDATA_W = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]         m_axis_tuser
);

  // A stalled result holds until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output changed before transfer");

  // The unit works on one sample at a time, so it is busy after an input transfer.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again while busy");

  // A new result only comes out of a busy unit.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work in flight");

  // Reset leaves the output empty and the input open.
  assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("reset did not clear the unit");

endmodule

bind biquad_iir_filter_unit biq_checker #(
  .TDATA_W(TDATA_W)
) u_biq_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

>>> tb/biquad_iir_filter_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the biquad IIR filter unit: directed and random samples
// under several coefficient settings, checked against a cycle-free filter predictor.
// Depends on biq_pkg and the biquad_iir_filter_unit RTL.
module biquad_iir_filter_unit_tb;
  import biq_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 24;
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int COEF_FRAC   = COEF_BITS - INT_BITS;
  localparam int HIST_BITS   = SAMPLE_BITS + HIST_EXTRA;
  localparam int LATENCY     = 9;
  localparam int IDLE_PCT    = 9;
  localparam int STALL_CYCLES = 80;
  localparam int PHASE_ITEMS  = 55;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [COEF_BITS-1:0]   COEF_ONE = COEF_BITS'(1 << COEF_FRAC);
  localparam logic signed [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] level;
    logic                          clipped;
  } filt_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_BITS-1:0] cfg_data = '0;

  // Predictor state: coefficients and filter history.
  logic signed [COEF_BITS-1:0]   coef [NUM_REGS];
  logic signed [SAMPLE_BITS-1:0] in_hist [2];
  logic signed [HIST_BITS-1:0]   out_hist [2];

  filt_result_t filt_expected_q[$];
  filt_result_t oldest_want;
  int           mismatches = 0;
  bit           idle_en = 1'b1;
  int           stall_ask = 0;
  int           stall_seen = 0;
  int           stall_left = 0;

  biquad_iir_filter_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Round half up: add half an LSB of the target, then floor.
  function automatic longint round_half_up(longint v, int shift);
    return (v + (longint'(1) << (shift - 1))) >>> shift;
  endfunction

  function automatic longint saturate(longint v, int bits, inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One filter step: feed-forward minus feedback, scaled by the reciprocal, saturated.
  function automatic filt_result_t predict_filter_output(logic signed [SAMPLE_BITS-1:0] x);
    longint       fwd;
    longint       fbk;
    longint       diff;
    longint       y;
    longint       lvl;
    logic         hit;
    filt_result_t r;
    hit = 1'b0;
    fwd = longint'(coef[REG_GAIN_NEWEST_IN]) * longint'(x)
        + longint'(coef[REG_GAIN_PREV_IN]) * longint'(in_hist[0])
        + longint'(coef[REG_GAIN_OLDEST_IN]) * longint'(in_hist[1]);
    fwd = fwd <<< HIST_EXTRA;
    fbk = longint'(coef[REG_GAIN_PREV_OUT]) * longint'(out_hist[0])
        + longint'(coef[REG_GAIN_OLDEST_OUT]) * longint'(out_hist[1]);
    diff = round_half_up(fwd - fbk, COEF_FRAC);
    y = round_half_up(diff * longint'(coef[REG_RECIP_LEAD_OUT]), COEF_FRAC);
    y = saturate(y, HIST_BITS, hit);
    lvl = saturate(round_half_up(y, HIST_EXTRA), SAMPLE_BITS, hit);
    in_hist[1] = in_hist[0];
    in_hist[0] = x;
    out_hist[1] = out_hist[0];
    out_hist[0] = y[HIST_BITS-1:0];
    r.level = lvl[SAMPLE_BITS-1:0];
    r.clipped = hit;
    return r;
  endfunction

  // Offer one sample, with random idle cycles ahead of it, and predict its result on transfer.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = x;
    do @(posedge clk); while (!s_axis_tready);
    filt_expected_q.push_back(predict_filter_output(x));
  endtask

  // Stop offering input and wait until every expected result has come out.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (filt_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // One register write; only called while the filter is idle.
  task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [COEF_BITS-1:0] val);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) coef[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all_coefs(input logic [COEF_BITS-1:0] val);
    for (int i = 0; i < NUM_REGS; i++) write_coef(REG_IDX_W'(i), val);
  endtask

  // Mostly full-range samples, some small ones and some at the extremes.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? SMP_MAX : SMP_MIN;
      1, 2:    return SAMPLE_BITS'(int'($urandom_range(8191)) - 4096);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Unity gain and reciprocal after reset: the output equals the input.
  task automatic test_default_passthrough();
    send_sample('0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    wait_drained();
  endtask

  // Writes to indexes past the last register must leave the filter unchanged.
  task automatic test_unused_index();
    write_coef(REG_IDX_W'(NUM_REGS), COEF_MAX);
    write_coef(REG_IDX_W'(NUM_REGS + 1), COEF_MIN);
    send_sample(16'sh1234);
    send_sample(-16'sh0ABC);
    send_sample(SMP_MAX);
    wait_drained();
  endtask

  // A slightly high reciprocal pushes the largest sample past the 16-bit range only
  // through the final rounding, with no clamp on the wide history value.
  task automatic test_round_into_clamp();
    write_coef(REG_RECIP_LEAD_OUT, COEF_BITS'(COEF_ONE + 19));
    write_coef(REG_GAIN_PREV_IN, '0);
    send_sample(SMP_MAX);
    send_sample(SMP_MAX - 16'sd1);
    send_sample(SMP_MIN);
    wait_drained();
  endtask

  // All coefficients at their extremes drive both clamps hard in both directions.
  task automatic test_coef_extremes();
    write_all_coefs(COEF_MAX);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample('0);
    send_sample(16'sd1);
    wait_drained();
    write_all_coefs(COEF_MIN);
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    send_sample('0);
    send_sample(-16'sd1);
    wait_drained();
  endtask

  // A stable low-pass section fed with steps, with no idling on either side.
  task automatic test_lowpass_steps();
    write_coef(REG_GAIN_NEWEST_IN, 24'sd70000);
    write_coef(REG_GAIN_PREV_IN, 24'sd140000);
    write_coef(REG_GAIN_OLDEST_IN, 24'sd70000);
    write_coef(REG_GAIN_PREV_OUT, -24'sd1195377);
    write_coef(REG_GAIN_OLDEST_OUT, 24'sd432013);
    write_coef(REG_RECIP_LEAD_OUT, COEF_ONE);
    idle_en = 1'b0;
    for (int i = 0; i < 40; i++) send_sample((i % 20) < 10 ? 16'sd8192 : -16'sd8192);
    wait_drained();
    idle_en = 1'b1;
  endtask

  // Random filters: most with poles inside the unit circle, some fully random.
  task automatic test_random_filters();
    int f2;
    int f1_lim;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 == 2) begin
        for (int i = 0; i < NUM_REGS; i++) write_coef(REG_IDX_W'(i), COEF_BITS'($urandom));
      end else begin
        f2 = int'($urandom_range(1887436)) - 943718;
        f1_lim = ((1048576 + f2) / 10) * 9;
        write_coef(REG_GAIN_NEWEST_IN, COEF_BITS'(int'($urandom_range(1048576)) - 524288));
        write_coef(REG_GAIN_PREV_IN, COEF_BITS'(int'($urandom_range(1048576)) - 524288));
        write_coef(REG_GAIN_OLDEST_IN, COEF_BITS'(int'($urandom_range(1048576)) - 524288));
        write_coef(REG_GAIN_PREV_OUT,
                   COEF_BITS'(int'($urandom_range(2 * f1_lim)) - f1_lim));
        write_coef(REG_GAIN_OLDEST_OUT, COEF_BITS'(f2));
        write_coef(REG_RECIP_LEAD_OUT, COEF_BITS'(int'($urandom_range(1048576)) + 524288));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(random_sample());
      wait_drained();
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_output_backpressure();
    stall_ask++;
    for (int n = 0; n < 30; n++) send_sample(random_sample());
    wait_drained();
  endtask

  // Receiver: random ready, or a counted hold-off when one is asked for.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (stall_ask != stall_seen) begin
      stall_seen = stall_ask;
      stall_left = STALL_CYCLES - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = !(idle_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each output transfer with the oldest expected result.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (filt_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected output transfer: level %0d clipped %0b",
                   $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser[0]);
      end else begin
        oldest_want = filt_expected_q.pop_front();
        if (m_axis_tdata[SAMPLE_BITS-1:0] !== oldest_want.level ||
            m_axis_tuser[0] !== oldest_want.clipped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Output mismatch: expected level %0d clipped %0b, got level %0d clipped %0b",
                     oldest_want.level, oldest_want.clipped,
                     $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser[0]);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_REGS; i++) coef[i] = '0;
    coef[REG_GAIN_NEWEST_IN] = COEF_ONE;
    coef[REG_RECIP_LEAD_OUT] = COEF_ONE;
    in_hist[0] = '0;
    in_hist[1] = '0;
    out_hist[0] = '0;
    out_hist[1] = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_default_passthrough();
    test_unused_index();
    test_round_into_clamp();
    test_coef_extremes();
    test_lowpass_steps();
    test_random_filters();
    test_output_backpressure();
    wait_drained();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
